@@ rtl/acpu_pkg.sv @@
// Shared types and constants for the pheromone trail update block.
// Used by acpu_front, acpu_back and ant_colony_pheromone_update.
package acpu_pkg;

    localparam int MAX_VERTICES_DEF  = 256;
    localparam int FRACTION_BITS_DEF = 24;
    localparam int CNT_W             = 9;
    localparam int VTX_W             = 8;
    localparam int DATA_W            = 32;
    localparam int STEP_W            = 5;
    localparam logic [CNT_W-1:0] VC_RESET = 9'd256;

    localparam logic [2:0] A_SET_ADJ = 3'd0;
    localparam logic [2:0] A_LOAD    = 3'd1;
    localparam logic [2:0] A_CLOSE   = 3'd2;
    localparam logic [2:0] A_END     = 3'd3;
    localparam logic [2:0] A_RD_PH   = 3'd4;
    localparam logic [2:0] A_RD_BEST = 3'd5;

    typedef struct packed {
        logic [2:0]       action;
        logic [VTX_W-1:0] row_vertex;
        logic [VTX_W-1:0] col_vertex;
        logic             edge_present;
        logic [VTX_W-1:0] vertex_colour;
        logic [CNT_W-1:0] colour_count;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              improved;
        logic [CNT_W-1:0]  best_count;
        logic              bad_count;
    } t_out;

    typedef struct packed {
        t_in  item;
        logic row_ok;
        logic col_ok;
    } t_cmd;

    typedef struct packed {
        logic             init_done;
        logic [CNT_W-1:0] n;
    } t_bstat;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DIV, S_CL_RD, S_CL_WR, S_EC_RD, S_EC_WR, S_RD, S_OUT
    } t_state;

endpackage

@@ rtl/acpu_front.sv @@
// Front end: accepts items, range-checks vertex indexes, queues them.
// Depends on acpu_pkg.
module acpu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  acpu_pkg::t_in   i_data,
    input  acpu_pkg::t_bstat i_stat,
    output logic            o_qvalid,
    output acpu_pkg::t_cmd  o_qcmd,
    input  logic            i_pop
);
    import acpu_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    assign o_ready  = (r_cnt != 2'd2) && i_stat.init_done;
    assign w_push   = i_valid && o_ready;
    assign o_qvalid = (r_cnt != 2'd0);
    assign o_qcmd   = r_q[r_rp];

    always_comb begin
        w_cmd.item   = i_data;
        w_cmd.row_ok = {1'b0, i_data.row_vertex} < i_stat.n;
        w_cmd.col_ok = {1'b0, i_data.col_vertex} < i_stat.n;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/acpu_back.sv @@
// Back end: matrix memories, clearing pass, divider, matrix walks, result register.
// Depends on acpu_pkg.
module acpu_back #(
    parameter int MAX_VERTICES  = acpu_pkg::MAX_VERTICES_DEF,
    parameter int FRACTION_BITS = acpu_pkg::FRACTION_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [acpu_pkg::CNT_W-1:0] i_cfg_data,
    input  logic             i_qvalid,
    input  acpu_pkg::t_cmd   i_qcmd,
    output logic             o_pop,
    output acpu_pkg::t_bstat o_stat,
    output logic             o_valid,
    input  logic             i_ready,
    output acpu_pkg::t_out   o_data
);
    import acpu_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int AW = 2 * VW;
    localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRACTION_BITS;

    function automatic logic [CNT_W-1:0] eff_n(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) r = CNT_W'(1);
        else if (32'(v) > MAX_VERTICES) r = CNT_W'(MAX_VERTICES);
        else r = v;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DATA_W] ? '1 : s[DATA_W-1:0];
    endfunction

    // memories
    logic [DATA_W-1:0] m_ph  [2**AW];
    logic [DATA_W-1:0] m_dep [2**AW];
    logic              m_adj [2**AW];
    logic [VTX_W-1:0]  m_cur [2**VW];
    logic [VTX_W-1:0]  m_best[2**VW];

    t_state             r_state, n_state;
    logic [AW-1:0]      r_k, n_k;
    t_cmd               r_cmd, n_cmd;
    t_out               r_res, n_res;
    logic               r_ov, n_ov;
    t_out               r_od, n_od;
    logic [CNT_W-1:0]   r_vc, n_vc;
    logic [CNT_W-1:0]   r_best, n_best;
    logic [CNT_W-1:0]   r_rem, n_rem;
    logic [DATA_W-1:0]  r_quo, n_quo;
    logic [STEP_W-1:0]  r_st, n_st;
    logic               r_impr, n_impr;
    logic               r_rdsel, n_rdsel;

    logic [DATA_W-1:0]  ph_rd, dep_rd;
    logic               adj_rd;
    logic [VTX_W-1:0]   ci_rd, cj_rd, best_rd;

    logic               ph_we, dep_we, adj_we, cur_we, best_we;
    logic [DATA_W-1:0]  ph_wd, dep_wd;
    logic               adj_wd;
    logic [AW-1:0]      adj_wa, ph_ra;
    logic [VW-1:0]      cur_wa, best_wa, best_ra;

    logic [CNT_W-1:0]   n;
    logic [VW-1:0]      q_row, q_col, k_i, k_j;
    logic [AW-1:0]      q_k;
    logic               last_i, last_j, i_in, j_in;
    logic [CNT_W:0]     rem_sh;
    logic               ge;

    assign n      = eff_n(r_vc);
    assign q_row  = VW'(i_qcmd.item.row_vertex);
    assign q_col  = VW'(i_qcmd.item.col_vertex);
    assign q_k    = {q_row, q_col};
    assign k_i    = r_k[AW-1:VW];
    assign k_j    = r_k[VW-1:0];
    assign last_i = (32'(k_i) == 32'(n) - 1);
    assign last_j = (32'(k_j) == 32'(n) - 1);
    assign i_in   = 32'(k_i) < 32'(n);
    assign j_in   = 32'(k_j) < 32'(n);
    assign rem_sh = {r_rem, (r_st == '0)};
    assign ge     = rem_sh >= {1'b0, r_cmd.item.colour_count};

    assign o_stat.init_done = (r_state != S_INIT);
    assign o_stat.n         = n;
    assign o_valid          = r_ov;
    assign o_data           = r_od;
    assign o_pop            = (r_state == S_IDLE) && i_qvalid;

    always_comb begin
        ph_ra   = (r_state == S_IDLE) ? q_k : r_k;
        best_ra = q_row;
        ph_we   = 1'b0;
        ph_wd   = ONE;
        dep_we  = 1'b0;
        dep_wd  = '0;
        adj_we  = 1'b0;
        adj_wd  = 1'b0;
        adj_wa  = r_k;
        cur_we  = 1'b0;
        cur_wa  = q_row;
        best_we = 1'b0;
        best_wa = k_i;
        case (r_state)
            S_INIT: begin
                ph_we  = 1'b1;
                dep_we = 1'b1;
                adj_we = 1'b1;
            end
            S_IDLE: begin
                if (i_qvalid && i_qcmd.item.action == A_SET_ADJ
                        && i_qcmd.row_ok && i_qcmd.col_ok) begin
                    adj_we = 1'b1;
                    adj_wd = i_qcmd.item.edge_present;
                    adj_wa = q_k;
                end
                if (i_qvalid && i_qcmd.item.action == A_LOAD && i_qcmd.row_ok) begin
                    cur_we = 1'b1;
                end
            end
            S_CL_WR: begin
                dep_we  = (k_i != k_j) && (ci_rd == cj_rd);
                dep_wd  = sat_add(dep_rd, r_quo);
                best_we = r_impr && (k_j == '0);
            end
            S_EC_WR: begin
                ph_we  = i_in && j_in && !adj_rd;
                ph_wd  = sat_add({1'b0, ph_rd[DATA_W-1:1]}, dep_rd);
                dep_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ph_we) m_ph[r_k] <= ph_wd;
        ph_rd <= m_ph[ph_ra];
    end

    always_ff @(posedge i_clk) begin
        if (dep_we) m_dep[r_k] <= dep_wd;
        dep_rd <= m_dep[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (adj_we) m_adj[adj_wa] <= adj_wd;
        adj_rd <= m_adj[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (cur_we) m_cur[cur_wa] <= i_qcmd.item.vertex_colour;
        ci_rd <= m_cur[k_i];
        cj_rd <= m_cur[k_j];
    end

    always_ff @(posedge i_clk) begin
        if (best_we) m_best[best_wa] <= ci_rd;
        best_rd <= m_best[best_ra];
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_cmd   = r_cmd;
        n_res   = r_res;
        n_vc    = r_vc;
        n_best  = r_best;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_st    = r_st;
        n_impr  = r_impr;
        n_rdsel = r_rdsel;
        n_ov    = r_ov && !i_ready;
        n_od    = r_od;
        if (i_cfg_we) begin
            n_vc   = i_cfg_data;
            n_best = eff_n(i_cfg_data);
        end
        case (r_state)
            S_INIT: begin
                n_k = r_k + AW'(1);
                if (r_k == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_qvalid) begin
                    n_cmd = i_qcmd;
                    n_res = '{read_value: '0, improved: 1'b0, best_count: r_best,
                              bad_count: 1'b0};
                    n_state = S_OUT;
                    case (i_qcmd.item.action)
                        A_CLOSE: begin
                            if (i_qcmd.item.colour_count == '0) begin
                                n_res.bad_count = 1'b1;
                            end else begin
                                n_impr = i_qcmd.item.colour_count < r_best;
                                if (i_qcmd.item.colour_count < r_best)
                                    n_best = i_qcmd.item.colour_count;
                                n_rem   = '0;
                                n_quo   = '0;
                                n_st    = '0;
                                n_state = S_DIV;
                            end
                        end
                        A_END: begin
                            n_k     = '0;
                            n_state = S_EC_RD;
                        end
                        A_RD_PH: begin
                            if (i_qcmd.row_ok && i_qcmd.col_ok) begin
                                n_rdsel = 1'b1;
                                n_state = S_RD;
                            end
                        end
                        A_RD_BEST: begin
                            if (i_qcmd.row_ok) begin
                                n_rdsel = 1'b0;
                                n_state = S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                // one quotient bit per cycle, MSB first
                n_rem = CNT_W'(ge ? rem_sh - {1'b0, r_cmd.item.colour_count} : rem_sh);
                n_quo = {r_quo[DATA_W-2:0], ge};
                n_st  = r_st + STEP_W'(1);
                if (32'(r_st) == FRACTION_BITS) begin
                    n_k     = '0;
                    n_state = S_CL_RD;
                end
            end
            S_CL_RD: n_state = S_CL_WR;
            S_CL_WR: begin
                if (last_i && last_j) begin
                    n_res = '{read_value: '0, improved: r_impr, best_count: r_best,
                              bad_count: 1'b0};
                    n_state = S_OUT;
                end else begin
                    n_k     = last_j ? {k_i + VW'(1), VW'(0)} : r_k + AW'(1);
                    n_state = S_CL_RD;
                end
            end
            S_EC_RD: n_state = S_EC_WR;
            S_EC_WR: begin
                // sweep the whole matrix so every deposit is cleared
                if (r_k == '1) begin
                    n_state = S_OUT;
                end else begin
                    n_k     = r_k + AW'(1);
                    n_state = S_EC_RD;
                end
            end
            S_RD: begin
                n_res.read_value = r_rdsel ? ph_rd : DATA_W'(best_rd);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || i_ready) begin
                    n_ov    = 1'b1;
                    n_od    = r_res;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_res   <= n_res;
        r_od    <= n_od;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_st    <= n_st;
        r_impr  <= n_impr;
        r_rdsel <= n_rdsel;
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_k     <= '0;
            r_ov    <= 1'b0;
            r_vc    <= VC_RESET;
            r_best  <= eff_n(VC_RESET);
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_ov    <= n_ov;
            r_vc    <= n_vc;
            r_best  <= n_best;
        end
    end

endmodule

@@ rtl/ant_colony_pheromone_update.sv @@
// Pheromone trail update top level; instantiates acpu_front and acpu_back.
// A close runs the divider, then a read-then-write deposit walk over the N x N matrix;
// an end of cycle walks the full matrix on one memory port. One item at a time in the back
// end: it takes a new item only once the result of the last one is in the output register.
// Reset: synchronous active low, then a clearing pass over all 4^ceil(log2(MAX_VERTICES))
// matrix entries (65536 by default) during which no item is accepted.
module ant_colony_pheromone_update #(
    parameter int MAX_VERTICES  = acpu_pkg::MAX_VERTICES_DEF,
    parameter int FRACTION_BITS = acpu_pkg::FRACTION_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  acpu_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output acpu_pkg::t_out o_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [acpu_pkg::CNT_W-1:0] i_cfg_data
);
    import acpu_pkg::*;

    logic   qvalid, pop;
    t_cmd   qcmd;
    t_bstat stat;

    assign o_cfg_ready = 1'b1;

    acpu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_stat   (stat),
        .o_qvalid (qvalid),
        .o_qcmd   (qcmd),
        .i_pop    (pop)
    );

    acpu_back #(
        .MAX_VERTICES  (MAX_VERTICES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_qvalid   (qvalid),
        .i_qcmd     (qcmd),
        .o_pop      (pop),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

endmodule

@@ test/ant_colony_pheromone_update_test.sv @@
// Self-checking testbench for ant_colony_pheromone_update.
// Drives directed and random items and checks the results against a model of the pheromone matrix.
// Depends on acpu_pkg and the block's RTL.
`timescale 1ns / 1ps

module ant_colony_pheromone_update_test;
    import acpu_pkg::*;

    localparam logic [2:0] A_SPARE6 = 3'd6;
    localparam logic [2:0] A_SPARE7 = 3'd7;
    localparam logic [31:0] PH_ONE = 32'h0100_0000;

    typedef struct {
        bit              is_cfg;
        logic [CNT_W-1:0] cfg;
        t_in             item;
        bit              typed;
        t_out            want;
    } t_row;

    logic i_clk, i_rst_n, i_valid, i_ready, i_cfg_valid;
    logic o_ready, o_valid, o_cfg_ready;
    t_in  i_data;
    t_out o_data;
    logic [CNT_W-1:0] i_cfg_data;

    ant_colony_pheromone_update dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // model state
    logic [31:0]      pher_mem [65536];
    logic [31:0]      depo_mem [65536];
    bit               adj_mem  [65536];
    logic [7:0]       cur_col  [256];
    logic [7:0]       best_col [256];
    bit               best_ok  [256];
    logic [CNT_W-1:0] vcount;
    logic [CNT_W-1:0] best_cnt;

    t_out pending_results[$];
    t_row dir_rows[$];
    int   mismatches = 0;
    int   results_seen = 0;
    int   items_sent = 0;
    int   hold_left = 0;
    bit   held = 0;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int eff_n(logic [CNT_W-1:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = a + b;
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic t_out trail_update(t_in it);
        t_out r;
        int n;
        logic [31:0] dep;
        n = eff_n(vcount);
        r = '0;
        case (it.action)
            A_SET_ADJ: if (it.row_vertex < n && it.col_vertex < n)
                adj_mem[{it.row_vertex, it.col_vertex}] = it.edge_present;
            A_LOAD: if (it.row_vertex < n) cur_col[it.row_vertex] = it.vertex_colour;
            A_CLOSE: begin
                if (it.colour_count == 0) begin
                    r.bad_count = 1;
                end else begin
                    dep = PH_ONE / it.colour_count;
                    for (int i = 0; i < n; i++)
                        for (int j = 0; j < n; j++)
                            if (i != j && cur_col[i] == cur_col[j])
                                depo_mem[i*256+j] = sat_add(depo_mem[i*256+j], dep);
                    if (it.colour_count < best_cnt) begin
                        best_cnt = it.colour_count;
                        r.improved = 1;
                        for (int i = 0; i < n; i++) begin
                            best_col[i] = cur_col[i];
                            best_ok[i] = 1;
                        end
                    end
                end
            end
            A_END: begin
                for (int k = 0; k < 65536; k++) begin
                    if ((k / 256) < n && (k % 256) < n && !adj_mem[k])
                        pher_mem[k] = sat_add(pher_mem[k] >> 1, depo_mem[k]);
                    depo_mem[k] = '0;
                end
            end
            A_RD_PH: if (it.row_vertex < n && it.col_vertex < n)
                r.read_value = pher_mem[{it.row_vertex, it.col_vertex}];
            A_RD_BEST: if (it.row_vertex < n) r.read_value = best_col[it.row_vertex];
            default: ;
        endcase
        r.best_count = best_cnt;
        return r;
    endfunction

    // result side: ready pattern with one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (!held && results_seen >= 120) begin
            held <= 1;
            hold_left <= 400;
            i_ready <= 1'b0;
        end else if (results_seen >= 600 && results_seen < 900) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= 23);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", o_data);
            end else begin
                want = pending_results.pop_front();
                if (o_data.read_value !== want.read_value || o_data.improved !== want.improved
                    || o_data.best_count !== want.best_count
                    || o_data.bad_count !== want.bad_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want val=%h imp=%b best=%0d bad=%b got val=%h imp=%b best=%0d bad=%b",
                                 want.read_value, want.improved, want.best_count, want.bad_count,
                                 o_data.read_value, o_data.improved, o_data.best_count,
                                 o_data.bad_count);
                end
            end
        end
    end

    // called at a falling edge; returns at a falling edge
    task automatic send_item(t_in it, bit typed, t_out want);
        t_out got;
        if (!(items_sent >= 300 && items_sent < 650) && $urandom_range(0, 99) < 23) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data = it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        got = trail_update(it);
        pending_results.push_back(typed ? want : got);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] v);
        i_valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        vcount = v;
        best_cnt = eff_n(v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_in mk(logic [2:0] a, logic [7:0] r, logic [7:0] c, logic e,
                               logic [7:0] col, logic [CNT_W-1:0] cnt);
        t_in it;
        it.action = a; it.row_vertex = r; it.col_vertex = c;
        it.edge_present = e; it.vertex_colour = col; it.colour_count = cnt;
        return it;
    endfunction

    function automatic void add_row(t_in it, bit typed = 0, logic [31:0] v = 0,
                                    logic imp = 0, logic [CNT_W-1:0] bc = 0, logic bad = 0);
        t_row rw;
        rw.is_cfg = 0; rw.cfg = 0; rw.item = it; rw.typed = typed;
        rw.want = '{read_value: v, improved: imp, best_count: bc, bad_count: bad};
        dir_rows.push_back(rw);
    endfunction

    function automatic void add_cfg(logic [CNT_W-1:0] v);
        t_row rw;
        rw = '{is_cfg: 1, cfg: v, item: '0, typed: 0, want: '0};
        dir_rows.push_back(rw);
    endfunction

    task automatic load_all(int n, int span);
        for (int v = 0; v < n; v++)
            send_item(mk(A_LOAD, v, $urandom, $urandom, $urandom_range(0, span), $urandom),
                      0, '0);
    endtask

    task automatic run_phase(logic [CNT_W-1:0] cfg, int count, int closes, int end_at);
        int n;
        int pick;
        t_in it;
        n = eff_n(cfg);
        write_count(cfg);
        load_all(n, 3);
        for (int k = 0; k < count; k++) begin
            it = t_in'({$urandom, $urandom});
            it.row_vertex = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, n-1);
            if ($urandom_range(0, 9) != 0) it.col_vertex = $urandom_range(0, n-1);
            pick = $urandom_range(0, 99);
            if (k == end_at) it.action = A_END;
            else if (pick < 25) begin
                it.action = A_LOAD;
                if ($urandom_range(0, 3) != 0) it.vertex_colour = $urandom_range(0, 3);
            end else if (pick < 40) it.action = A_SET_ADJ;
            else if (pick < 55 && closes > 0) begin
                it.action = A_CLOSE;
                closes--;
                pick = $urandom_range(0, 9);
                if (pick == 0) it.colour_count = 0;
                else if (pick > 2) it.colour_count = $urandom_range(1, n + 2);
            end else if (pick < 80) it.action = A_RD_PH;
            else if (pick < 92) it.action = A_RD_BEST;
            else it.action = $urandom_range(0, 1) ? A_SPARE6 : A_SPARE7;
            // never read a best colour that was never stored
            if (it.action == A_RD_BEST && it.row_vertex < n && !best_ok[it.row_vertex])
                it.action = A_RD_PH;
            send_item(it, 0, '0);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        for (int k = 0; k < 65536; k++) begin
            pher_mem[k] = PH_ONE;
            depo_mem[k] = '0;
            adj_mem[k] = 0;
        end
        for (int k = 0; k < 256; k++) begin
            cur_col[k] = '0; best_col[k] = '0; best_ok[k] = 0;
        end
        vcount = VC_RESET;
        best_cnt = eff_n(VC_RESET);

        add_row(mk(A_RD_PH, 0, 0, 0, 0, 0), 1, PH_ONE, 0, 256, 0);
        add_row(mk(A_RD_PH, 255, 255, 1, 255, 511), 1, PH_ONE, 0, 256, 0);
        add_row(mk(A_SPARE6, 0, 0, 0, 0, 0), 1, 0, 0, 256, 0);
        add_row(mk(A_SPARE7, 255, 255, 1, 255, 511), 1, 0, 0, 256, 0);
        add_row(mk(A_SET_ADJ, 255, 0, 1, 0, 0));
        add_cfg(9'd4);
        add_row(mk(A_LOAD, 0, 0, 0, 0, 0));
        add_row(mk(A_LOAD, 1, 0, 0, 255, 0));
        add_row(mk(A_LOAD, 2, 0, 0, 0, 0));
        add_row(mk(A_LOAD, 3, 0, 0, 7, 0));
        add_row(mk(A_LOAD, 200, 0, 0, 9, 0));
        add_row(mk(A_CLOSE, 0, 0, 0, 0, 0), 1, 0, 0, 4, 1);
        add_row(mk(A_CLOSE, 0, 0, 0, 0, 3), 1, 0, 1, 3, 0);
        add_row(mk(A_CLOSE, 0, 0, 0, 0, 256), 1, 0, 0, 3, 0);
        add_row(mk(A_CLOSE, 0, 0, 0, 0, 1), 1, 0, 1, 1, 0);
        add_row(mk(A_RD_BEST, 1, 0, 0, 0, 0), 1, 255, 0, 1, 0);
        add_row(mk(A_RD_BEST, 200, 0, 0, 0, 0), 1, 0, 0, 1, 0);
        add_row(mk(A_RD_PH, 0, 200, 0, 0, 0), 1, 0, 0, 1, 0);
        add_row(mk(A_SET_ADJ, 0, 2, 1, 0, 0));
        add_row(mk(A_END, 0, 0, 0, 0, 0));
        add_row(mk(A_RD_PH, 0, 2, 0, 0, 0), 1, PH_ONE, 0, 1, 0);
        add_row(mk(A_RD_PH, 2, 0, 0, 0, 0));
        add_row(mk(A_RD_PH, 1, 3, 0, 0, 0));

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_count(VC_RESET);
        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) write_count(dir_rows[k].cfg);
            else send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
        end

        // saturate the deposits, then the pheromone entries
        write_count(9'd2);
        send_item(mk(A_LOAD, 0, 0, 0, 5, 0), 0, '0);
        send_item(mk(A_LOAD, 1, 0, 0, 5, 0), 0, '0);
        repeat (260) send_item(mk(A_CLOSE, 0, 0, 0, 0, 1), 0, '0);
        send_item(mk(A_END, 0, 0, 0, 0, 0), 0, '0);
        send_item(mk(A_RD_PH, 0, 1, 0, 0, 0), 0, '0);
        send_item(mk(A_RD_PH, 1, 0, 0, 0, 0), 0, '0);
        send_item(mk(A_RD_PH, 1, 1, 0, 0, 0), 0, '0);

        run_phase(9'd0, 150, 40, -1);
        run_phase(9'd7, 400, 80, -1);
        run_phase(9'd16, 400, 80, 250);
        run_phase(9'd511, 100, 1, -1);
        run_phase(9'd3, 150, 40, -1);

        i_valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
